[src/float32_magnitude_adder_core_macros.svh]
// Assertion macros for the float32 magnitude adder core
`ifndef FLOAT32_MAGNITUDE_ADDER_CORE_MACROS_SVH
`define FLOAT32_MAGNITUDE_ADDER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FMA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FMA_ASSERT_IMPL(label, ante, cons, msg)
`define FMA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[src/fma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fma_pkg
// Widths and stage record types shared by the magnitude adder core.
// ----------------------------------------------------------------------------
package fma_pkg;
	localparam int FRAC_BITS = 23;
	localparam int EXP_BITS  = 8;
	localparam int SIG_BITS  = FRAC_BITS + 1;
	localparam int SHIFT_BITS = $clog2(SIG_BITS + 1);

	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [EXP_BITS-1:0]  exp_t;
	typedef logic [SIG_BITS-1:0]  sig_t;

	// operands after ordering
	typedef struct packed {
		logic  bypass;
		logic  byp_sign;
		exp_t  byp_exp;
		frac_t byp_frac;
		logic  l_sign;
		exp_t  l_exp;
		frac_t l_frac;
		frac_t s_frac;
		exp_t  diff;
	} ord_t;
endpackage

[src/fma_align.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fma_align
// Barrel shift of the smaller significand by the exponent difference.
// ----------------------------------------------------------------------------
module fma_align (
	input  fma_pkg::frac_t s_frac,
	input  fma_pkg::exp_t  diff,
	output fma_pkg::sig_t  sig
);
	import fma_pkg::*;

	always_comb begin
		if (diff > exp_t'(FRAC_BITS)) begin
			sig = '0;
		end else begin
			sig = {1'b1, s_frac} >> diff[SHIFT_BITS-1:0];
		end
	end
endmodule

[src/float32_magnitude_adder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_magnitude_adder_core
// Three-stage pipelined magnitude adder for single-precision fields.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low. Each result passes
// through the compare, align and add/normalize register stages, in that
// order, before it is on the output. A stall freezes all stages only when
// the pipeline is full; bubbles are squeezed out.
`include "float32_magnitude_adder_core_macros.svh"
module float32_magnitude_adder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           a_sign,
	input  fma_pkg::exp_t  a_exp,
	input  fma_pkg::frac_t a_frac,
	input  logic           b_sign,
	input  fma_pkg::exp_t  b_exp,
	input  fma_pkg::frac_t b_frac,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           sum_sign,
	output fma_pkg::exp_t  sum_exp,
	output fma_pkg::frac_t sum_frac,
	output logic           exp_overflow
);
	import fma_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	ord_t ord_c, ord_s1, ord_s2;
	sig_t small_c, small_s2;
	logic [SIG_BITS:0] sum_c;
	logic a_zero, b_zero, a_big;
	logic sign_s3, ovf_s3;
	exp_t exp_s3;
	frac_t frac_s3;

	assign adv3 = !v_s3 || !out_stall;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	// stage 1: zero detect and ordering
	always_comb begin
		a_zero = (a_exp == '0) && (a_frac == '0);
		b_zero = (b_exp == '0) && (b_frac == '0);
		a_big = (a_exp > b_exp) || ((a_exp == b_exp) && (a_frac > b_frac));
		ord_c.bypass   = a_zero || b_zero;
		ord_c.byp_sign = a_zero ? b_sign : a_sign;
		ord_c.byp_exp  = a_zero ? b_exp : a_exp;
		ord_c.byp_frac = a_zero ? b_frac : a_frac;
		ord_c.l_sign   = a_big ? a_sign : b_sign;
		ord_c.l_exp    = a_big ? a_exp : b_exp;
		ord_c.l_frac   = a_big ? a_frac : b_frac;
		ord_c.s_frac   = a_big ? b_frac : a_frac;
		ord_c.diff     = a_big ? (a_exp - b_exp) : (b_exp - a_exp);
	end

	// stage 2: align
	fma_align u_align (
		.s_frac(ord_s1.s_frac),
		.diff  (ord_s1.diff),
		.sig   (small_c)
	);

	// stage 3: add and normalize
	assign sum_c = {1'b0, 1'b1, ord_s2.l_frac} + {1'b0, small_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) ord_s1 <= ord_c;
		if (adv2 && v_s1) begin
			ord_s2   <= ord_s1;
			small_s2 <= small_c;
		end
		if (adv3 && v_s2) begin
			if (ord_s2.bypass) begin
				sign_s3 <= ord_s2.byp_sign;
				exp_s3  <= ord_s2.byp_exp;
				frac_s3 <= ord_s2.byp_frac;
				ovf_s3  <= 1'b0;
			end else begin
				sign_s3 <= ord_s2.l_sign;
				if (sum_c[SIG_BITS]) begin
					exp_s3  <= ord_s2.l_exp + exp_t'(1);
					frac_s3 <= sum_c[FRAC_BITS:1];
					ovf_s3  <= (ord_s2.l_exp == '1);
				end else begin
					exp_s3  <= ord_s2.l_exp;
					frac_s3 <= sum_c[FRAC_BITS-1:0];
					ovf_s3  <= 1'b0;
				end
			end
		end
	end

	assign out_valid    = v_s3;
	assign sum_sign     = sign_s3;
	assign sum_exp      = exp_s3;
	assign sum_frac     = frac_s3;
	assign exp_overflow = ovf_s3;

	`FMA_ASSERT_IMPL(a_ovf_zero_exp, out_valid && exp_overflow, sum_exp == '0,
		"overflow with nonzero exponent")
	`FMA_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(sum_frac),
		"stalled result changed")
	`FMA_ASSERT_IMPL(a_stall_full, in_stall, v_s1 && v_s2 && v_s3 && out_stall,
		"input stalled with a bubble in the pipe")
endmodule
